// ===== src/segment_box_collision_point_top_macros.svh =====
// Assertion macros for the segment to box collision point block.
// Included by the checker; relies on clk_i and rst_ni in the including scope.
`ifndef SEGMENT_BOX_COLLISION_POINT_TOP_MACROS_SVH
`define SEGMENT_BOX_COLLISION_POINT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbcp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbcp assertion failed");

`endif

// ===== src/sbcp_pkg.sv =====
// Shared types for the segment to box collision point block.
// No dependencies.
`timescale 1ns / 1ps

package sbcp_pkg;

  typedef enum logic [1:0] {
    SIDE_BOTTOM = 2'd0,
    SIDE_TOP    = 2'd1,
    SIDE_LEFT   = 2'd2,
    SIDE_RIGHT  = 2'd3
  } side_e;

  typedef struct packed {
    logic  hit;
    side_e side;
    logic  neg;
  } sbcp_ctl_t;

endpackage

// ===== src/sbcp_geom.sv =====
// Geometry front end: box corners, cross products, side selection and the
// dividend and divisor of the crossing point. Four register stages; uses sbcp_pkg.
`timescale 1ns / 1ps

module sbcp_geom import sbcp_pkg::*; #(
  parameter int CB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [CB-1:0] near_x_i,
  input  logic signed [CB-1:0] near_y_i,
  input  logic signed [CB-1:0] far_x_i,
  input  logic signed [CB-1:0] far_y_i,
  input  logic signed [CB-1:0] box_center_x_i,
  input  logic signed [CB-1:0] box_center_y_i,
  input  logic        [CB-2:0] box_width_i,
  input  logic        [CB-2:0] box_height_i,
  output logic                 valid_o,
  input  logic                 ds_ready_i,
  output sbcp_ctl_t            ctl_o,
  output logic      [2*CB+3:0] num_o,
  output logic        [CB:0]   den_o,
  output logic      [CB-1:0]   fix_o
);

  localparam int W1 = CB + 2;
  localparam int WN = 2 * CB + 4;

  function automatic logic opp(input logic signed [W1-1:0] a, input logic signed [W1-1:0] b,
                               input logic signed [W1-1:0] m);
    return (a < m && b > m) || (a > m && b < m);
  endfunction

  logic [3:0] v_q;
  logic [3:0] en;

  assign en[3]   = !v_q[3] || ds_ready_i;
  assign en[2]   = !v_q[2] || en[3];
  assign en[1]   = !v_q[1] || en[2];
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];
  assign valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  // Stage A: corners and differences.
  logic signed [W1-1:0] hw_s, hh_s, cx_s, cy_s, p1x_s, p1y_s, p2x_s, p2y_s;
  logic signed [W1-1:0] l_s, r_s, b_s, t_s;
  logic signed [W1-1:0] a_rx_q, a_ry_q, a_dxl_q, a_dxr_q, a_dyb_q, a_dyt_q;
  logic signed [W1-1:0] a_p1x_q, a_p1y_q, a_p2x_q, a_p2y_q;
  logic signed [W1-1:0] a_l_q, a_r_q, a_b_q, a_t_q;
  logic                 a_wnz_q, a_hnz_q;

  assign hw_s  = signed'({4'b0000, box_width_i[CB-2:1]});
  assign hh_s  = signed'({4'b0000, box_height_i[CB-2:1]});
  assign cx_s  = signed'({{2{box_center_x_i[CB-1]}}, box_center_x_i});
  assign cy_s  = signed'({{2{box_center_y_i[CB-1]}}, box_center_y_i});
  assign p1x_s = signed'({{2{far_x_i[CB-1]}}, far_x_i});
  assign p1y_s = signed'({{2{far_y_i[CB-1]}}, far_y_i});
  assign p2x_s = signed'({{2{near_x_i[CB-1]}}, near_x_i});
  assign p2y_s = signed'({{2{near_y_i[CB-1]}}, near_y_i});
  assign l_s   = cx_s - hw_s;
  assign r_s   = cx_s + hw_s;
  assign b_s   = cy_s - hh_s;
  assign t_s   = cy_s + hh_s;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_rx_q  <= p2x_s - p1x_s;
      a_ry_q  <= p2y_s - p1y_s;
      a_dxl_q <= l_s - p1x_s;
      a_dxr_q <= r_s - p1x_s;
      a_dyb_q <= b_s - p1y_s;
      a_dyt_q <= t_s - p1y_s;
      a_p1x_q <= p1x_s;
      a_p1y_q <= p1y_s;
      a_p2x_q <= p2x_s;
      a_p2y_q <= p2y_s;
      a_l_q   <= l_s;
      a_r_q   <= r_s;
      a_b_q   <= b_s;
      a_t_q   <= t_s;
      a_wnz_q <= |box_width_i[CB-2:1];
      a_hnz_q <= |box_height_i[CB-2:1];
    end
  end

  // Stage B: products and strict crossing of the side lines.
  logic signed [WN-1:0] b_rdyb_q, b_rdyt_q, b_rdxl_q, b_rdxr_q, b_pxry_q, b_pyrx_q;
  logic signed [W1-1:0] b_rx_q, b_ry_q, b_l_q, b_r_q, b_b_q, b_t_q;
  logic                 b_vb_q, b_vt_q, b_vl_q, b_vr_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_rdyb_q <= WN'(a_rx_q) * WN'(a_dyb_q);
      b_rdyt_q <= WN'(a_rx_q) * WN'(a_dyt_q);
      b_rdxl_q <= WN'(a_ry_q) * WN'(a_dxl_q);
      b_rdxr_q <= WN'(a_ry_q) * WN'(a_dxr_q);
      b_pxry_q <= WN'(a_p1x_q) * WN'(a_ry_q);
      b_pyrx_q <= WN'(a_p1y_q) * WN'(a_rx_q);
      b_rx_q   <= a_rx_q;
      b_ry_q   <= a_ry_q;
      b_l_q    <= a_l_q;
      b_r_q    <= a_r_q;
      b_b_q    <= a_b_q;
      b_t_q    <= a_t_q;
      b_vb_q   <= a_wnz_q && opp(a_p1y_q, a_p2y_q, a_b_q);
      b_vt_q   <= a_wnz_q && opp(a_p1y_q, a_p2y_q, a_t_q);
      b_vl_q   <= a_hnz_q && opp(a_p1x_q, a_p2x_q, a_l_q);
      b_vr_q   <= a_hnz_q && opp(a_p1x_q, a_p2x_q, a_r_q);
    end
  end

  // Stage C: corner line tests and candidate dividends.
  logic signed [WN-1:0] f_lb, f_rb, f_lt, f_rt;
  logic signed [WN-1:0] c_nb_q, c_nt_q, c_nl_q, c_nr_q;
  logic [3:0]           c_neg_q, c_nz_q;
  logic signed [W1-1:0] c_rx_q, c_ry_q, c_l_q, c_r_q, c_b_q, c_t_q;
  logic                 c_vb_q, c_vt_q, c_vl_q, c_vr_q;

  assign f_lb = b_rdyb_q - b_rdxl_q;
  assign f_rb = b_rdyb_q - b_rdxr_q;
  assign f_lt = b_rdyt_q - b_rdxl_q;
  assign f_rt = b_rdyt_q - b_rdxr_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_neg_q <= {f_rt[WN-1], f_lt[WN-1], f_rb[WN-1], f_lb[WN-1]};
      c_nz_q  <= {|f_rt, |f_lt, |f_rb, |f_lb};
      c_nb_q  <= b_pxry_q + b_rdyb_q;
      c_nt_q  <= b_pxry_q + b_rdyt_q;
      c_nl_q  <= b_pyrx_q + b_rdxl_q;
      c_nr_q  <= b_pyrx_q + b_rdxr_q;
      c_rx_q  <= b_rx_q;
      c_ry_q  <= b_ry_q;
      c_l_q   <= b_l_q;
      c_r_q   <= b_r_q;
      c_b_q   <= b_b_q;
      c_t_q   <= b_t_q;
      c_vb_q  <= b_vb_q;
      c_vt_q  <= b_vt_q;
      c_vl_q  <= b_vl_q;
      c_vr_q  <= b_vr_q;
    end
  end

  // Stage D: first side hit, magnitudes and quotient sign.
  logic                 hb, ht, hl, hr;
  logic signed [WN-1:0] n_sel;
  logic signed [W1-1:0] d_sel, fix_sel;
  logic [WN-1:0]        n_abs;
  logic [W1-1:0]        d_abs;
  sbcp_ctl_t            ctl_d;

  assign hb = c_vb_q && c_nz_q[0] && c_nz_q[1] && (c_neg_q[0] != c_neg_q[1]);
  assign ht = c_vt_q && c_nz_q[2] && c_nz_q[3] && (c_neg_q[2] != c_neg_q[3]);
  assign hl = c_vl_q && c_nz_q[0] && c_nz_q[2] && (c_neg_q[0] != c_neg_q[2]);
  assign hr = c_vr_q && c_nz_q[1] && c_nz_q[3] && (c_neg_q[1] != c_neg_q[3]);

  always_comb begin
    ctl_d.hit = hb || ht || hl || hr;
    priority if (hb) begin
      ctl_d.side = SIDE_BOTTOM;
      n_sel      = c_nb_q;
      d_sel      = c_ry_q;
      fix_sel    = c_b_q;
    end else if (ht) begin
      ctl_d.side = SIDE_TOP;
      n_sel      = c_nt_q;
      d_sel      = c_ry_q;
      fix_sel    = c_t_q;
    end else if (hl) begin
      ctl_d.side = SIDE_LEFT;
      n_sel      = c_nl_q;
      d_sel      = c_rx_q;
      fix_sel    = c_l_q;
    end else if (hr) begin
      ctl_d.side = SIDE_RIGHT;
      n_sel      = c_nr_q;
      d_sel      = c_rx_q;
      fix_sel    = c_r_q;
    end else begin
      ctl_d.side = SIDE_BOTTOM;
      n_sel      = c_nb_q;
      d_sel      = c_ry_q;
      fix_sel    = c_b_q;
    end
    ctl_d.neg = n_sel[WN-1] ^ d_sel[W1-1];
    n_abs     = n_sel[WN-1] ? WN'(-n_sel) : WN'(n_sel);
    d_abs     = d_sel[W1-1] ? W1'(-d_sel) : W1'(d_sel);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ctl_o <= ctl_d;
      num_o <= n_abs;
      den_o <= d_abs[CB:0];
      fix_o <= fix_sel[CB-1:0];
    end
  end

endmodule

// ===== src/sbcp_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage, CB stages.
// Carries the side control and fixed coordinate along; uses sbcp_pkg.
`timescale 1ns / 1ps

module sbcp_div import sbcp_pkg::*; #(
  parameter int CB = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sbcp_ctl_t         ctl_i,
  input  logic [2*CB+3:0]   num_i,
  input  logic [CB:0]       den_i,
  input  logic [CB-1:0]     fix_i,
  output logic              valid_o,
  input  logic              ds_ready_i,
  output sbcp_ctl_t         ctl_o,
  output logic [CB-1:0]     quo_o,
  output logic [CB-1:0]     fix_o
);

  logic [CB-1:0] v_q;
  logic [CB-1:0] en;
  logic [CB:0]   r_q   [CB];
  logic [CB-1:0] nq_q  [CB];
  logic [CB:0]   den_q [CB];
  logic [CB-1:0] fix_q [CB];
  sbcp_ctl_t     ctl_q [CB];

  for (genvar k = 0; k < CB; k++) begin : g_step
    logic          v_src;
    logic [CB:0]   r_src;
    logic [CB-1:0] nq_src;
    logic [CB:0]   den_src;
    logic [CB-1:0] fix_src;
    sbcp_ctl_t     ctl_src;
    logic [CB+1:0] t_w;
    logic [CB+1:0] diff_w;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_src   = valid_i;
      assign r_src   = num_i[2*CB:CB];
      assign nq_src  = num_i[CB-1:0];
      assign den_src = den_i;
      assign fix_src = fix_i;
      assign ctl_src = ctl_i;
    end else begin : g_next
      assign v_src   = v_q[k-1];
      assign r_src   = r_q[k-1];
      assign nq_src  = nq_q[k-1];
      assign den_src = den_q[k-1];
      assign fix_src = fix_q[k-1];
      assign ctl_src = ctl_q[k-1];
    end

    if (k == CB - 1) begin : g_last
      assign en[k] = !v_q[k] || ds_ready_i;
    end else begin : g_mid
      assign en[k] = !v_q[k] || en[k+1];
    end

    assign t_w    = {r_src, nq_src[CB-1]};
    assign ge     = t_w >= {1'b0, den_src};
    assign diff_w = t_w - {1'b0, den_src};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        r_q[k]   <= ge ? diff_w[CB:0] : t_w[CB:0];
        nq_q[k]  <= {nq_src[CB-2:0], ge};
        den_q[k] <= den_src;
        fix_q[k] <= fix_src;
        ctl_q[k] <= ctl_src;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[CB-1];
  assign ctl_o   = ctl_q[CB-1];
  assign quo_o   = nq_q[CB-1];
  assign fix_o   = fix_q[CB-1];

endmodule

// ===== src/segment_box_collision_point_top.sv =====
// Top level of the segment to box collision point block.
// Instantiates sbcp_geom and sbcp_div; uses sbcp_pkg.
//
// One beat on the input channel carries a segment (near and far point) and a
// box (centre, width, height). One beat on the output channel carries whether
// the segment strictly crosses a box side, the first side crossed in the order
// bottom, top, left, right, and the crossing point truncated toward zero.
// A miss gives all result fields zero.
// Both channels use valid and stall; a beat moves on a rising edge with valid
// high and stall low.
// The pipeline holds four geometry stages, one divider stage per quotient bit
// and the output register.
// A new beat is taken every cycle while in_stall_o is low. When the receiver stalls,
// the output holds and the pipeline keeps filling its empty stages; in_stall_o
// rises only once every stage holds a beat.
// Reset clears all valid bits; the block takes a beat in the first cycle
// after reset is released.
`timescale 1ns / 1ps

module segment_box_collision_point_top import sbcp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] near_x_i,
  input  logic signed [COORD_BITS-1:0] near_y_i,
  input  logic signed [COORD_BITS-1:0] far_x_i,
  input  logic signed [COORD_BITS-1:0] far_y_i,
  input  logic signed [COORD_BITS-1:0] box_center_x_i,
  input  logic signed [COORD_BITS-1:0] box_center_y_i,
  input  logic        [COORD_BITS-2:0] box_width_i,
  input  logic        [COORD_BITS-2:0] box_height_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic                  [1:0]  hit_side_o,
  output logic signed [COORD_BITS-1:0] hit_x_o,
  output logic signed [COORD_BITS-1:0] hit_y_o
);

  localparam int CB = COORD_BITS;

  logic            geom_ready, geom_valid, div_ready, div_valid, out_en, out_valid_q;
  sbcp_ctl_t       geom_ctl, div_ctl;
  logic [2*CB+3:0] geom_num;
  logic [CB:0]     geom_den;
  logic [CB-1:0]   geom_fix, div_quo, div_fix, q_signed;
  logic            hit_q;
  logic [1:0]      side_q;
  logic [CB-1:0]   x_q, y_q;

  sbcp_geom #(.CB(CB)) u_geom (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (geom_ready),
    .near_x_i       (near_x_i),
    .near_y_i       (near_y_i),
    .far_x_i        (far_x_i),
    .far_y_i        (far_y_i),
    .box_center_x_i (box_center_x_i),
    .box_center_y_i (box_center_y_i),
    .box_width_i    (box_width_i),
    .box_height_i   (box_height_i),
    .valid_o        (geom_valid),
    .ds_ready_i     (div_ready),
    .ctl_o          (geom_ctl),
    .num_o          (geom_num),
    .den_o          (geom_den),
    .fix_o          (geom_fix)
  );

  sbcp_div #(.CB(CB)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (geom_valid),
    .ready_o    (div_ready),
    .ctl_i      (geom_ctl),
    .num_i      (geom_num),
    .den_i      (geom_den),
    .fix_i      (geom_fix),
    .valid_o    (div_valid),
    .ds_ready_i (out_en),
    .ctl_o      (div_ctl),
    .quo_o      (div_quo),
    .fix_o      (div_fix)
  );

  assign out_en     = !out_valid_q || !out_stall_i;
  assign in_stall_o = !geom_ready;
  assign q_signed   = div_ctl.neg ? CB'(-div_quo) : div_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      hit_q  <= div_ctl.hit;
      side_q <= div_ctl.hit ? div_ctl.side : SIDE_BOTTOM;
      if (!div_ctl.hit) begin
        x_q <= '0;
        y_q <= '0;
      end else if (div_ctl.side == SIDE_BOTTOM || div_ctl.side == SIDE_TOP) begin
        x_q <= q_signed;
        y_q <= div_fix;
      end else begin
        x_q <= div_fix;
        y_q <= q_signed;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign hit_side_o  = side_q;
  assign hit_x_o     = signed'(x_q);
  assign hit_y_o     = signed'(y_q);

endmodule

// ===== src/sbcp_checker.sv =====
// Port-level checker for the segment to box collision point block, bound to
// the top level. Uses sbcp_pkg and the block's assertion macro header.
`timescale 1ns / 1ps
`include "segment_box_collision_point_top_macros.svh"

module sbcp_checker import sbcp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         hit_o,
  input logic                  [1:0]  hit_side_o,
  input logic signed [COORD_BITS-1:0] hit_x_o,
  input logic signed [COORD_BITS-1:0] hit_y_o
);

  logic                      miss_clean;
  logic [2*COORD_BITS+2:0]   out_bundle;

  assign miss_clean = (hit_side_o == SIDE_BOTTOM) && (hit_x_o == '0) && (hit_y_o == '0);
  assign out_bundle = {hit_o, hit_side_o, hit_x_o, hit_y_o};

  // An empty or draining output register lets the whole pipeline advance.
  `SBCP_ASSERT_IMP(a_idle_ready, !out_valid_o || !out_stall_i, !in_stall_o)
  `SBCP_ASSERT_IMP(a_miss_zero, out_valid_o && !hit_o, miss_clean)
  `SBCP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `SBCP_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_bundle))

endmodule

bind segment_box_collision_point_top sbcp_checker #(.COORD_BITS(COORD_BITS)) u_sbcp_checker (.*);
